>>> hw/rtl/tccs_pkg.sv
// Shared definitions for the text console cursor and scroll unit.
// Holds request kind codes, terminal control characters and cell constants.
// No dependencies.
package tccs_pkg;

  typedef enum logic [1:0] {
    KIND_TERM  = 2'd0,
    KIND_PLACE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0]  RESET_ATTR = 8'h07;
  localparam logic [15:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

  // Register indexes of the configuration port (word addresses).
  localparam logic [0:0] REG_NORMAL_ATTR = 1'b0;

endpackage

>>> hw/rtl/tccs_addr_alu.sv
// Shared address adder of the console unit: sum = a + b, minus one on request.
// Used for cell addresses, scroll destinations and the linear cursor position.
// No dependencies.
module tccs_addr_alu #(
  parameter int unsigned W = 12
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         dec_i,
  output logic [W-1:0] sum_o
);

  assign sum_o = a_i + b_i - W'(dec_i);

endmodule

>>> hw/rtl/tccs_screen_mem.sv
// Screen cell store of the console unit: one write port, one read port.
// Read data is registered. No dependencies.
module tccs_screen_mem #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11,
  parameter int unsigned DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/text_console_cursor_scroll_unit.sv
// Text console engine: a ROWS x COLS store of 16-bit cells (attribute in the high
// byte, character in the low byte) with a terminal cursor. Each transaction is run by
// a small sequencer around one shared address adder and a single-port-write screen
// memory: a terminal character (printable, CR, LF, backspace or NUL), a cell
// placement, a cell read or a screen clear. A scroll copies the store one cell a
// cycle and then fills the bottom row. After reset the memory is initialized by a
// pass over every cell, during which no transaction is accepted; configuration
// writes are taken at any time. The result register frees the input side as soon
// as the result is loaded.
module text_console_cursor_scroll_unit #(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  row_i,
  input  logic [7:0]  col_i,
  input  logic [7:0]  attr_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o,
  output logic [10:0] cursor_pos_o,
  output logic [15:0] read_data_o,
  output logic        scrolled_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import tccs_pkg::*;

  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CNTW  = $clog2(CELLS + 1);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);

  localparam logic [CNTW-1:0] CellsC      = CNTW'(CELLS);
  localparam logic [CNTW-1:0] LastCell    = CNTW'(CELLS - 1);
  localparam logic [CNTW-1:0] ColsC       = CNTW'(COLS);
  localparam logic [CNTW-1:0] LastRowBase = CNTW'((ROWS - 1) * COLS);
  localparam logic [CNTW-1:0] ScrollBack  = CNTW'(COLS + 1);
  localparam logic [RW-1:0]   LastRow     = RW'(ROWS - 1);
  localparam logic [CW-1:0]   LastCol     = CW'(COLS - 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_CALC   = 3'd2;
  localparam logic [2:0] S_ADDR   = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_SCROLL = 3'd5;
  localparam logic [2:0] S_FILL   = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  logic [2:0]      state_q;
  logic [CNTW-1:0] cnt_q;
  logic [RW-1:0]   cur_row_q;
  logic [CW-1:0]   cur_col_q;
  logic [CNTW-1:0] row_base_q;
  logic [7:0]      normal_attr_q;
  logic            out_valid_q;
  logic            scr_q;
  logic [15:0]     rd_q;

  // Latched transaction payload.
  logic [1:0]      kind_q;
  logic [7:0]      ch_q;
  logic [7:0]      r_q;
  logic [7:0]      c_q;
  logic [7:0]      at_q;
  logic [CNTW-1:0] prod_q;

  // Result registers.
  logic [4:0]      res_row_q;
  logic [6:0]      res_col_q;
  logic [10:0]     res_pos_q;
  logic [15:0]     res_rd_q;
  logic            res_scr_q;

  logic [CNTW-1:0] alu_a;
  logic [CNTW-1:0] alu_b;
  logic            alu_dec;
  logic [CNTW-1:0] alu_sum;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [15:0]     mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [15:0]     mem_rdata;

  logic            in_fire;
  logic            resp_load;
  logic            in_range;
  logic            is_term;
  logic            is_ctrl;
  logic            is_print;
  logic            bs_write;
  logic            go_next_row;
  logic            cfg_write;
  logic [15:0]     blank_cell;

  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign resp_load  = (state_q == S_RESP) && (!out_valid_q || out_ready_i);
  assign in_range   = (r_q < 8'(ROWS)) && (c_q < 8'(COLS));
  assign blank_cell = {normal_attr_q, CH_SPACE};

  assign is_term  = (kind_q == KIND_TERM);
  assign is_ctrl  = (ch_q == CH_CR) || (ch_q == CH_LF) || (ch_q == CH_BS) ||
                    (ch_q == CH_NUL);
  assign is_print = is_term && !is_ctrl;
  assign bs_write = is_term && (ch_q == CH_BS) && (cur_col_q != '0);
  // A line feed, or a printable character written in the last column.
  assign go_next_row = is_term && ((ch_q == CH_LF) || (!is_ctrl && cur_col_q == LastCol));

  tccs_addr_alu #(
    .W (CNTW)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .dec_i (alu_dec),
    .sum_o (alu_sum)
  );

  tccs_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (16)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Operand selection of the shared adder.
  always_comb begin
    alu_a   = row_base_q;
    alu_b   = CNTW'(cur_col_q);
    alu_dec = 1'b0;
    unique case (state_q)
      S_CALC: begin
        alu_dec = bs_write;
      end
      S_ADDR: begin
        alu_a = prod_q;
        alu_b = CNTW'(c_q);
      end
      S_SCROLL: begin
        // Destination lags the source by one row plus the read latency.
        alu_a = cnt_q;
        alu_b = CNTW'(0) - ScrollBack;
      end
      default: begin
      end
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = alu_sum[AW-1:0];
    mem_wdata = blank_cell;
    mem_re    = 1'b0;
    mem_raddr = alu_sum[AW-1:0];
    unique case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        mem_wdata = RESET_CELL;
      end
      S_CALC: begin
        mem_we    = is_print || bs_write;
        mem_wdata = is_print ? {normal_attr_q, ch_q} : blank_cell;
      end
      S_ADDR: begin
        mem_we    = in_range && (kind_q == KIND_PLACE);
        mem_wdata = {at_q, ch_q};
        mem_re    = in_range && (kind_q == KIND_READ);
      end
      S_SCROLL: begin
        mem_re    = (cnt_q != CellsC);
        mem_raddr = cnt_q[AW-1:0];
        mem_we    = (cnt_q != ColsC);
        mem_wdata = mem_rdata;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Sequencer and cursor state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      cnt_q      <= '0;
      cur_row_q  <= '0;
      cur_col_q  <= '0;
      row_base_q <= '0;
      out_valid_q <= 1'b0;
      scr_q      <= 1'b0;
      rd_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !resp_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          cnt_q <= cnt_q + CNTW'(1);
          if (cnt_q == LastCell) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            scr_q   <= 1'b0;
            rd_q    <= '0;
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          unique case (kind_e'(kind_q))
            KIND_TERM: begin
              state_q <= S_RESP;
              if ((ch_q == CH_CR) || go_next_row) begin
                cur_col_q <= '0;
              end else if (bs_write) begin
                cur_col_q <= cur_col_q - CW'(1);
              end else if (is_print) begin
                cur_col_q <= cur_col_q + CW'(1);
              end
              if (go_next_row) begin
                if (cur_row_q == LastRow) begin
                  scr_q   <= 1'b1;
                  cnt_q   <= ColsC;
                  state_q <= S_SCROLL;
                end else begin
                  cur_row_q  <= cur_row_q + RW'(1);
                  row_base_q <= row_base_q + ColsC;
                end
              end
            end
            KIND_PLACE, KIND_READ: begin
              state_q <= S_ADDR;
            end
            KIND_CLEAR: begin
              cur_row_q  <= '0;
              cur_col_q  <= '0;
              row_base_q <= '0;
              cnt_q      <= '0;
              state_q    <= S_FILL;
            end
            default: begin
              state_q <= S_RESP;
            end
          endcase
        end
        S_ADDR: begin
          state_q <= (mem_re) ? S_READ : S_RESP;
        end
        S_READ: begin
          rd_q    <= mem_rdata;
          state_q <= S_RESP;
        end
        S_SCROLL: begin
          if (cnt_q == CellsC) begin
            cnt_q   <= LastRowBase;
            state_q <= S_FILL;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        S_FILL: begin
          if (cnt_q == LastCell) begin
            state_q <= S_RESP;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        S_RESP: begin
          if (resp_load) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload capture; the row product is formed the cycle before address generation.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_i;
      ch_q   <= char_code_i;
      r_q    <= row_i;
      c_q    <= col_i;
      at_q   <= attr_i;
    end
    if (state_q == S_CALC) begin
      prod_q <= CNTW'(r_q[RW-1:0] * COLS);
    end
    if (resp_load) begin
      res_row_q <= 5'(cur_row_q);
      res_col_q <= 7'(cur_col_q);
      res_pos_q <= 11'(alu_sum);
      res_rd_q  <= rd_q;
      res_scr_q <= scr_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cursor_row_o = res_row_q;
  assign cursor_col_o = res_col_q;
  assign cursor_pos_o = res_pos_q;
  assign read_data_o  = res_rd_q;
  assign scrolled_o   = res_scr_q;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_NORMAL_ATTR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_attr_q <= RESET_ATTR;
    end else if (cfg_write) begin
      normal_attr_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_NORMAL_ATTR) ? {24'h0, normal_attr_q} : 32'h0;

`ifndef SYNTHESIS
  // A scroll always leaves the cursor at the start of the bottom row.
  a_scroll_cursor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> (cursor_row_o == 5'(ROWS - 1)) && (cursor_col_o == '0))
    else $error("scroll result with cursor off the bottom row start");

  // The cursor column never reaches the line length.
  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, cursor_col_o} < 8'(COLS)))
    else $error("cursor column out of range");

  // The screen store is untouched while the unit waits for a transaction.
  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("screen store written while idle");

  // An accepted transaction leaves the idle state on the next cycle.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("unit still ready after accepting a transaction");
`endif

endmodule
